/* rtl/pfds_pkg.sv */
package pfds_pkg;

    // reported width of every counter field
    localparam int CNT_OUT_W   = 24;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_FILM   = 2'd1,
        MODE_RAW    = 2'd2,
        MODE_SPARE  = 2'd3
    } t_mode;

    typedef enum logic {
        CFG_OUTPUT_MODE     = 1'b0,
        CFG_PROGRESSIVE_SEQ = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        WR_NONE   = 2'd0,
        WR_TOP    = 2'd1,
        WR_BOTTOM = 2'd2,
        WR_BOTH   = 2'd3
    } t_written;

    typedef enum logic [1:0] {
        VERDICT_DROP  = 2'd0,
        VERDICT_ONCE  = 2'd1,
        VERDICT_TWICE = 2'd2,
        VERDICT_SPARE = 2'd3
    } t_verdict;

    localparam logic signed [3:0] LOCK_LIMIT    = 4'sd3;
    localparam logic signed [3:0] TRIGGER_LIMIT = 4'sd5;

    typedef struct packed {
        logic [1:0] field_flags;
        logic       first_frame;
    } t_in_word;

    typedef struct packed {
        logic [1:0]           field_written;
        logic                 show;
        logic [CNT_OUT_W-1:0] playback_index;
        logic [CNT_OUT_W-1:0] frame_repeat_count;
        logic [CNT_OUT_W-1:0] field_repeat_count;
        logic [CNT_OUT_W-1:0] film_count;
        logic [CNT_OUT_W-1:0] video_count;
        logic                 last;
    } t_out_word;

    // one classified frame, front to back
    typedef struct packed {
        logic                 first;
        logic                 prog;
        logic                 tff;
        logic                 field_rep;
        logic [1:0]           n_stores;   // interlaced: field-pair writes, 0..2
        logic [1:0]           prog_last;  // progressive: index of final frame write
        logic [CNT_OUT_W-1:0] field_rep_cnt;
        logic [CNT_OUT_W-1:0] film_cnt;
        logic [CNT_OUT_W-1:0] video_cnt;
    } t_cmd;

endpackage

/* rtl/pfds_front.sv */
module pfds_front
    import pfds_pkg::*;
#(
    parameter int COUNT_BITS = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [1:0] i_cfg_data,
    input  logic       i_in_valid,
    input  t_in_word   i_in_word,
    output logic       o_in_stall,
    input  logic       i_q_full,
    output logic       o_q_push,
    output t_cmd       o_q_cmd
);

    logic [1:0]            r_mode;
    logic                  r_prog;
    logic [1:0]            r_prev;
    logic signed [3:0]     r_bal;
    logic                  r_locked;
    logic [COUNT_BITS-1:0] r_film;
    logic [COUNT_BITS-1:0] r_video;
    logic [COUNT_BITS-1:0] r_frep;

    logic signed [3:0]     n_bal;
    logic                  n_locked;
    logic [COUNT_BITS-1:0] n_film;
    logic [COUNT_BITS-1:0] n_video;
    logic [COUNT_BITS-1:0] n_frep;

    logic              first, tff, rep, film_mode, raw_mode, film_match;
    logic [1:0]        flags;
    logic signed [3:0] bal_base, bal_sum, lim;
    logic              locked_base;
    t_verdict          verdict;
    logic              accept;

    assign flags     = i_in_word.field_flags;
    assign first     = i_in_word.first_frame;
    assign tff       = flags[1];
    assign rep       = flags[0];
    assign film_mode = (r_mode == MODE_FILM);
    assign raw_mode  = (r_mode == MODE_RAW);
    assign accept    = i_in_valid && !i_q_full;

    assign o_in_stall = i_q_full;
    assign o_q_push   = accept;

    always_comb begin
        if (r_prog) begin
            film_match = (flags == 2'd3 && r_prev == 2'd1) || (flags == 2'd1 && r_prev == 2'd3);
        end else begin
            film_match = (flags == 2'(r_prev + 2'd1));
        end
    end

    // purity counts and field repeat count, cleared on the first frame
    always_comb begin
        if (first) begin
            n_film  = '0;
            n_video = '0;
            n_frep  = '0;
        end else begin
            n_film  = r_film;
            n_video = r_video;
            n_frep  = r_frep;
            if (film_match) begin
                n_film = (r_film == '1) ? r_film : r_film + 1'b1;
            end else begin
                n_video = (r_video == '1) ? r_video : r_video + 1'b1;
            end
        end
        if (!r_prog && !raw_mode && rep) begin
            n_frep = (n_frep == '1) ? n_frep : n_frep + 1'b1;
        end
    end

    // repeat balance: lock at +-3, then trigger at +-5
    always_comb begin
        bal_base    = first ? 4'sd0 : r_bal;
        locked_base = first ? 1'b0 : r_locked;
        bal_sum     = bal_base + (rep ? 4'sd1 : -4'sd1);
        lim         = locked_base ? TRIGGER_LIMIT : LOCK_LIMIT;
        n_bal       = bal_base;
        n_locked    = locked_base;
        verdict     = VERDICT_DROP;
        if (!r_prog) begin
            priority if (bal_sum == -lim) begin
                n_bal    = 4'sd0;
                n_locked = 1'b1;
                verdict  = VERDICT_DROP;
            end else if (bal_sum == lim) begin
                n_bal    = 4'sd0;
                n_locked = 1'b1;
                verdict  = VERDICT_TWICE;
            end else begin
                n_bal   = bal_sum;
                verdict = VERDICT_ONCE;
            end
        end
    end

    always_comb begin
        o_q_cmd.first         = first;
        o_q_cmd.prog          = r_prog;
        o_q_cmd.tff           = tff;
        o_q_cmd.field_rep     = !film_mode && !raw_mode && rep;
        o_q_cmd.field_rep_cnt = CNT_OUT_W'(n_frep);
        o_q_cmd.film_cnt      = CNT_OUT_W'(n_film);
        o_q_cmd.video_cnt     = CNT_OUT_W'(n_video);
        if (!raw_mode && rep) begin
            o_q_cmd.prog_last = tff ? 2'd2 : 2'd1;
        end else begin
            o_q_cmd.prog_last = 2'd0;
        end
        if (film_mode) begin
            o_q_cmd.n_stores = (verdict != VERDICT_DROP) ? 2'd1 : 2'd0;
        end else begin
            o_q_cmd.n_stores = (verdict == VERDICT_TWICE) ? 2'd2 : 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_NORMAL;
            r_prog   <= 1'b0;
            r_prev   <= 2'd0;
            r_bal    <= 4'sd0;
            r_locked <= 1'b0;
            r_film   <= '0;
            r_video  <= '0;
            r_frep   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_OUTPUT_MODE:     r_mode <= i_cfg_data;
                    CFG_PROGRESSIVE_SEQ: r_prog <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_prev   <= flags;
                r_bal    <= n_bal;
                r_locked <= n_locked;
                r_film   <= n_film;
                r_video  <= n_video;
                r_frep   <= n_frep;
            end
        end
    end

endmodule

/* rtl/pfds_queue.sv */
module pfds_queue
    import pfds_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* rtl/pfds_back.sv */
module pfds_back
    import pfds_pkg::*;
#(
    parameter int COUNT_BITS = 24
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    logic                  r_top;
    logic                  r_bot;
    logic [COUNT_BITS-1:0] r_shown;
    logic [COUNT_BITS-1:0] r_frame_rep;
    logic                  r_store;     // which field-pair write of the frame
    logic [1:0]            r_step;      // word within the store or progressive run
    logic                  r_first_top;
    logic                  r_out_valid;
    t_out_word             r_out;

    logic                  first_ev, clr;
    logic                  eff_top, eff_bot, top_set, bot_set, sh;
    logic [COUNT_BITS-1:0] eff_shown, eff_frame_rep;
    t_written              wr;
    logic                  store_last, is_last, zero_ev, can_emit, fire, pop;

    assign first_ev      = !r_store && (r_step == 2'd0);
    assign clr           = first_ev && i_cmd.first;
    assign eff_top       = clr ? 1'b0 : r_top;
    assign eff_bot       = clr ? 1'b0 : r_bot;
    assign eff_shown     = clr ? '0 : r_shown;
    assign eff_frame_rep = clr ? '0 : r_frame_rep;

    always_comb begin
        if (i_cmd.prog) begin
            wr = WR_BOTH;
        end else begin
            unique case (r_step)
                2'd0:    wr = eff_bot ? WR_TOP : WR_BOTTOM;
                2'd1:    wr = r_first_top ? WR_BOTTOM : WR_TOP;
                default: wr = i_cmd.tff ? WR_TOP : WR_BOTTOM;
            endcase
        end
    end

    assign top_set    = eff_top | wr[0];
    assign bot_set    = eff_bot | wr[1];
    assign sh         = top_set && bot_set;
    assign store_last = i_cmd.field_rep ? (r_step == 2'd2) : (r_step == 2'd1);
    assign is_last    = i_cmd.prog ? (r_step == i_cmd.prog_last)
                                   : (store_last && (2'({1'b0, r_store}) + 2'd1 == i_cmd.n_stores));
    assign zero_ev    = !i_cmd.prog && (i_cmd.n_stores == 2'd0);
    assign can_emit   = !r_out_valid || !i_out_stall;
    assign fire       = i_cmd_valid && !zero_ev && can_emit;
    assign pop        = i_cmd_valid && (zero_ev || (fire && is_last));

    assign o_cmd_pop   = pop;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out.field_written      <= wr;
            r_out.show               <= sh;
            r_out.playback_index     <= CNT_OUT_W'(eff_shown);
            r_out.frame_repeat_count <= CNT_OUT_W'(eff_frame_rep);
            r_out.field_repeat_count <= i_cmd.field_rep_cnt;
            r_out.film_count         <= i_cmd.film_cnt;
            r_out.video_count        <= i_cmd.video_cnt;
            r_out.last               <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top       <= 1'b0;
            r_bot       <= 1'b0;
            r_shown     <= '0;
            r_frame_rep <= '0;
            r_store     <= 1'b0;
            r_step      <= 2'd0;
            r_first_top <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (fire) begin
                if (sh) begin
                    r_top   <= 1'b0;
                    r_bot   <= 1'b0;
                    r_shown <= (eff_shown == '1) ? eff_shown : eff_shown + 1'b1;
                end else begin
                    r_top   <= top_set;
                    r_bot   <= bot_set;
                    r_shown <= eff_shown;
                end
                // progressive repeat count rises after each repeated frame write
                if (i_cmd.prog && r_step != 2'd0) begin
                    r_frame_rep <= (eff_frame_rep == '1) ? eff_frame_rep
                                                         : eff_frame_rep + 1'b1;
                end else begin
                    r_frame_rep <= eff_frame_rep;
                end
                if (r_step == 2'd0) begin
                    r_first_top <= (wr == WR_TOP);
                end
                priority if (is_last) begin
                    r_step  <= 2'd0;
                    r_store <= 1'b0;
                end else if (!i_cmd.prog && store_last) begin
                    r_step  <= 2'd0;
                    r_store <= 1'b1;
                end else begin
                    r_step <= r_step + 2'd1;
                end
            end else if (pop && i_cmd.first) begin
                // dropped frame still restarts the display state
                r_top       <= 1'b0;
                r_bot       <= 1'b0;
                r_shown     <= '0;
                r_frame_rep <= '0;
            end
        end
    end

endmodule

/* rtl/pulldown_field_display_sequencer_unit.sv */
// Pulldown field display sequencer. Each input word is one decoded frame (field flags and a
// first-frame mark); the block runs the film/video cadence detector and emits 0 to 6 field
// write / show words per frame, the final one marked last. The front classifies one frame per
// cycle into a 4-entry queue while the queue is not full; the back issues one output word per
// cycle from the queue head while the output is not stalled. Configuration (output mode,
// progressive sequence) is written through a plain write port; the user must write it only
// while the block is idle, which the block itself does not enforce. Counters saturate at
// 2^COUNT_BITS-1 and are reported in 24 bits.
module pulldown_field_display_sequencer_unit
    import pfds_pkg::*;
#(
    parameter int COUNT_BITS = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [1:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_word   i_in_word,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_word  o_out_word
);

    logic q_full, q_push, q_pop, q_valid;
    t_cmd q_in, q_head;

    pfds_front #(
        .COUNT_BITS(COUNT_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .o_in_stall (o_in_stall),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_cmd    (q_in)
    );

    pfds_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_cmd  (q_in),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_cmd  (q_head)
    );

    pfds_back #(
        .COUNT_BITS(COUNT_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(q_valid),
        .i_cmd      (q_head),
        .o_cmd_pop  (q_pop),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

endmodule
